>>> hdl/rscd_pkg.sv
// Package for the RGB skin classifier with 3x3 dilation.
// Holds sizes, register codes, reset values and the per-pixel functions.
// Used by rgb_skin_classifier_dilate_top; depends on nothing else.
`default_nettype none

package rscd_pkg;

    // Frame limits and derived widths.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;

    // Field widths fixed by the register map and the pixel format.
    localparam int SIZE_W = 11;
    localparam int POS_W  = 10;
    localparam int CH_W   = 8;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // Result queue between the pipeline and the output port.
    localparam int Q_DEPTH = 3;
    localparam int Q_PTR_W = 2;

    // Register indexes (byte address is four times the index).
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROI_X        = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROI_Y        = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROI_WIDTH    = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROI_HEIGHT   = 3'd5;
    localparam logic [IDX_W-1:0] REG_RED_MIN      = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPREAD_MIN   = 3'd7;

    // Register reset values.
    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 11'd480;
    localparam logic [POS_W-1:0]  RST_ROI_X        = 10'd0;
    localparam logic [POS_W-1:0]  RST_ROI_Y        = 10'd0;
    localparam logic [SIZE_W-1:0] RST_ROI_WIDTH    = 11'd640;
    localparam logic [SIZE_W-1:0] RST_ROI_HEIGHT   = 11'd480;
    localparam logic [CH_W-1:0]   RST_RED_MIN      = 8'd95;
    localparam logic [CH_W-1:0]   RST_SPREAD_MIN   = 8'd15;

    // Fixed thresholds of the skin rule.
    localparam logic [CH_W-1:0] GREEN_MIN   = 8'd40;
    localparam logic [CH_W-1:0] BLUE_MIN    = 8'd20;
    localparam logic [CH_W-1:0] RG_DIFF_MIN = 8'd15;

    // Which window neighbors lie inside the frame.
    typedef struct packed {
        logic left_ok;
        logic right_ok;
        logic top_ok;
        logic bottom_ok;
    } t_edge;

    // One result beat.
    typedef struct packed {
        logic skin;
        logic frame_end;
    } t_res;

    // Explicit RGB skin rule.
    function automatic logic f_classify(
        input logic [CH_W-1:0] r,
        input logic [CH_W-1:0] g,
        input logic [CH_W-1:0] b,
        input logic [CH_W-1:0] red_min,
        input logic [CH_W-1:0] spread_min
    );
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] mn;
        logic [CH_W-1:0] diff;
        begin
            mx = r;
            mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            diff = (r > g) ? (r - g) : (g - r);
            return (r > red_min) && (g > GREEN_MIN) && (b > BLUE_MIN) &&
                   ((mx - mn) > spread_min) && (diff > RG_DIFF_MIN) &&
                   (r > b) && (r > g);
        end
    endfunction

    // OR of one window column, with the rows outside the frame masked.
    function automatic logic f_col_or(input logic [2:0] col, input t_edge e);
        begin
            return (col[0] & e.top_ok) | col[1] | (col[2] & e.bottom_ok);
        end
    endfunction

    // 3x3 dilation. The window holds three columns, the newest in the top
    // slot. When the center is the top slot there is no right neighbor.
    function automatic logic f_dilate(
        input logic [8:0] win,
        input logic       center_top,
        input t_edge      e
    );
        logic c0;
        logic c1;
        logic c2;
        begin
            c0 = f_col_or(win[2:0], e);
            c1 = f_col_or(win[5:3], e);
            c2 = f_col_or(win[8:6], e);
            if (center_top) begin
                return c2 | (c1 & e.left_ok);
            end else begin
                return c1 | (c0 & e.left_ok) | (c2 & e.right_ok);
            end
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/rgb_skin_classifier_dilate_top.sv
// Top level of the RGB skin classifier with 3x3 dilation.
// Holds the register file, the line store memory and the two-stage pipeline.
// Depends on rscd_pkg.
`default_nettype none

// The block takes one beat per clock, pixel or drain, and keeps that rate for
// as long as the result side takes a beat per clock. Each beat passes through
// the position and classification stage, which also issues the line store
// read, and then the window stage, which gets the read data, updates the 3x3
// window and writes the column back. The line store is one memory of 1024
// entries by two bits (line above, middle line), read and written once per
// beat; when one column is read in the same cycle as it is written, the
// written value is forwarded. A dilated mask bit leaves frame_width + 1 beats
// after its pixel, so the host follows each frame with frame_width + 1 drain
// beats; the first frame_width + 1 beats of a frame give no result. A
// three-entry result queue decouples the two sides, and o_ready comes from
// registers only. After reset the line store clears all 1024 entries, during
// which o_ready stays low; register writes are taken as usual.
module rgb_skin_classifier_dilate_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration port.
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [rscd_pkg::ADDR_W-1:0]        paddr,
    input  wire  [rscd_pkg::DATA_W-1:0]        pwdata,
    output logic [rscd_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    // Input channel.
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire                                i_op,
    input  wire  [rscd_pkg::CH_W-1:0]          i_red,
    input  wire  [rscd_pkg::CH_W-1:0]          i_green,
    input  wire  [rscd_pkg::CH_W-1:0]          i_blue,
    // Output channel.
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic                               o_skin,
    output logic                               o_frame_end
);
    import rscd_pkg::*;

    // Configuration registers.
    logic [SIZE_W-1:0] r_frame_w;
    logic [SIZE_W-1:0] r_frame_h;
    logic [POS_W-1:0]  r_roi_x;
    logic [POS_W-1:0]  r_roi_y;
    logic [SIZE_W-1:0] r_roi_w;
    logic [SIZE_W-1:0] r_roi_h;
    logic [CH_W-1:0]   r_red_min;
    logic [CH_W-1:0]   r_spread_min;

    logic             cfg_wr;
    logic [IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes at the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w    <= RST_FRAME_WIDTH;
            r_frame_h    <= RST_FRAME_HEIGHT;
            r_roi_x      <= RST_ROI_X;
            r_roi_y      <= RST_ROI_Y;
            r_roi_w      <= RST_ROI_WIDTH;
            r_roi_h      <= RST_ROI_HEIGHT;
            r_red_min    <= RST_RED_MIN;
            r_spread_min <= RST_SPREAD_MIN;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_WIDTH:  r_frame_w    <= pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: r_frame_h    <= pwdata[SIZE_W-1:0];
                REG_ROI_X:        r_roi_x      <= pwdata[POS_W-1:0];
                REG_ROI_Y:        r_roi_y      <= pwdata[POS_W-1:0];
                REG_ROI_WIDTH:    r_roi_w      <= pwdata[SIZE_W-1:0];
                REG_ROI_HEIGHT:   r_roi_h      <= pwdata[SIZE_W-1:0];
                REG_RED_MIN:      r_red_min    <= pwdata[CH_W-1:0];
                REG_SPREAD_MIN:   r_spread_min <= pwdata[CH_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = DATA_W'(r_frame_w);
            REG_FRAME_HEIGHT: prdata = DATA_W'(r_frame_h);
            REG_ROI_X:        prdata = DATA_W'(r_roi_x);
            REG_ROI_Y:        prdata = DATA_W'(r_roi_y);
            REG_ROI_WIDTH:    prdata = DATA_W'(r_roi_w);
            REG_ROI_HEIGHT:   prdata = DATA_W'(r_roi_h);
            REG_RED_MIN:      prdata = DATA_W'(r_red_min);
            REG_SPREAD_MIN:   prdata = DATA_W'(r_spread_min);
            default:          prdata = '0;
        endcase
    end

    // Frame size clamped to 1..MAX, and the last column and line.
    logic [SIZE_W-1:0] w_cl;
    logic [SIZE_W-1:0] h_cl;
    logic [COL_W-1:0]  w_last;
    logic [ROW_W-1:0]  h_last;

    always_comb begin
        if (r_frame_w == '0) begin
            w_cl = SIZE_W'(1);
        end else if (r_frame_w > SIZE_W'(MAX_WIDTH)) begin
            w_cl = SIZE_W'(MAX_WIDTH);
        end else begin
            w_cl = r_frame_w;
        end
        if (r_frame_h == '0) begin
            h_cl = SIZE_W'(1);
        end else if (r_frame_h > SIZE_W'(MAX_HEIGHT)) begin
            h_cl = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_cl = r_frame_h;
        end
        w_last = COL_W'(w_cl - SIZE_W'(1));
        h_last = ROW_W'(h_cl - SIZE_W'(1));
    end

    // Position counters, the clearing pass and the pipeline registers.
    logic [COL_W-1:0]   r_in_col;
    logic [ROW_W-1:0]   r_in_row;
    logic [COL_W-1:0]   r_out_col;
    logic [ROW_W-1:0]   r_out_row;
    logic               r_clr_busy;
    logic [COL_W-1:0]   r_clr_addr;

    logic               r_b_vld;
    logic               r_b_res;
    logic               r_b_fe;
    logic               r_b_m;
    logic               r_b_col0;
    logic [COL_W-1:0]   r_b_col;
    t_edge              r_b_edge;
    logic               r_fwd;
    logic [1:0]         r_fwd_data;
    logic [8:0]         r_win;

    logic [1:0]         mem [MAX_WIDTH];
    logic [1:0]         r_rdata;

    t_res               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W-1:0] r_cnt;

    // Stage A: classification, position bookkeeping and line store read.
    logic               acc_in;
    logic               in_roi;
    logic               m_bit;
    logic               item_res;
    logic               item_fe;
    logic [COL_W-1:0]   dx;
    logic [ROW_W-1:0]   dy;
    logic [COL_W-1:0]   n_in_col;
    logic [ROW_W-1:0]   n_in_row;
    logic [COL_W-1:0]   n_out_col;
    logic [ROW_W-1:0]   n_out_row;
    t_edge              item_edge;

    assign acc_in = i_valid && o_ready;
    assign dx     = r_in_col - COL_W'(r_roi_x);
    assign dy     = r_in_row - ROW_W'(r_roi_y);

    always_comb begin
        in_roi = (r_in_row < ROW_W'(h_cl)) && (SIZE_W'(r_in_col) < w_cl) &&
                 (r_in_col >= COL_W'(r_roi_x)) && (SIZE_W'(dx) < r_roi_w) &&
                 (r_in_row >= ROW_W'(r_roi_y)) && (SIZE_W'(dy) < r_roi_h);
        m_bit  = !i_op && in_roi &&
                 f_classify(i_red, i_green, i_blue, r_red_min, r_spread_min);

        // A result appears once the stream is a line and a pixel deep.
        item_res = (r_in_row >= ROW_W'(2)) ||
                   ((r_in_row == ROW_W'(1)) && (r_in_col != '0));
        item_fe  = (r_out_row >= h_last) && (r_out_col >= w_last);

        item_edge.left_ok   = (r_out_col != '0);
        item_edge.right_ok  = !(r_out_col >= w_last);
        item_edge.top_ok    = (r_out_row != '0);
        item_edge.bottom_ok = !(r_out_row >= h_last);

        // Input position; the line count saturates at its largest value.
        if (r_in_col >= w_last) begin
            n_in_col = '0;
            n_in_row = (r_in_row == '1) ? r_in_row : r_in_row + ROW_W'(1);
        end else begin
            n_in_col = r_in_col + COL_W'(1);
            n_in_row = r_in_row;
        end

        // Output position; the frame end restarts every position counter.
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (item_res) begin
            if (item_fe) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (r_out_col >= w_last) begin
                n_out_col = '0;
                n_out_row = (r_out_row == '1) ? r_out_row : r_out_row + ROW_W'(1);
            end else begin
                n_out_col = r_out_col + COL_W'(1);
            end
        end
    end

    // Stage B: merge the read data, shift the window and dilate.
    logic [1:0] rd_eff;
    logic [8:0] n_win;
    logic [1:0] wr_data;
    logic       res_skin;

    always_comb begin
        rd_eff   = r_fwd ? r_fwd_data : r_rdata;
        n_win    = {r_b_m, rd_eff[1], rd_eff[0], r_win[8:3]};
        wr_data  = {r_b_m, rd_eff[1]};
        // Column zero of the stream closes the previous line: center on the
        // old window's newest column, otherwise on the shifted window.
        res_skin = r_b_col0 ? f_dilate(r_win, 1'b1, r_b_edge)
                            : f_dilate(n_win, 1'b0, r_b_edge);
    end

    // Line store: bit 0 is the line above, bit 1 the middle line.
    logic             mem_we;
    logic [COL_W-1:0] mem_wa;
    logic [1:0]       mem_wd;

    assign mem_we = r_clr_busy || r_b_vld;
    assign mem_wa = r_clr_busy ? r_clr_addr : r_b_col;
    assign mem_wd = r_clr_busy ? 2'b00 : wr_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (acc_in) begin
            r_rdata <= mem[r_in_col];
        end
    end

    // Pipeline control and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_b_vld    <= 1'b0;
            r_win      <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + COL_W'(1);
                if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_b_vld <= acc_in;
            if (acc_in) begin
                r_in_col  <= n_in_col;
                r_in_row  <= n_in_row;
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
            if (r_b_vld) begin
                r_win <= n_win;
            end
        end
    end

    // Stage B payload; the forward flag catches a write to the column just read.
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_b_res    <= item_res;
            r_b_fe     <= item_fe;
            r_b_m      <= m_bit;
            r_b_col0   <= (r_in_col == '0);
            r_b_col    <= r_in_col;
            r_b_edge   <= item_edge;
            r_fwd      <= r_b_vld && (r_b_col == r_in_col);
            r_fwd_data <= wr_data;
        end
    end

    // Result queue.
    logic push;
    logic pop;
    t_res push_res;

    assign push     = r_b_vld && r_b_res;
    assign pop      = o_valid && i_ready;
    assign push_res = '{skin: res_skin, frame_end: r_b_fe};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + Q_PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + Q_PTR_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - Q_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= push_res;
        end
    end

    // A new beat is taken while the queue has room for everything in flight.
    assign o_ready     = !r_clr_busy &&
                         ((3'(r_cnt) + 3'(r_b_vld)) < 3'(Q_DEPTH));
    assign o_valid     = (r_cnt != '0);
    assign o_skin      = r_q[r_rp].skin;
    assign o_frame_end = r_q[r_rp].frame_end;

endmodule

`default_nettype wire

>>> hdl/rscd_checker.sv
// Port-level checker for rgb_skin_classifier_dilate_top, and its bind.
// Sees only the top-level ports, all one bit wide; uses no package.
`default_nettype none

module rscd_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         pready,
    input wire                         o_ready,
    input wire                         o_valid,
    input wire                         i_ready,
    input wire                         o_skin,
    input wire                         o_frame_end
);

    // Reset empties the result queue and starts the line store clearing pass.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_ready))
        else $error("result pending or input open right after reset");

    // The configuration port never inserts wait states.
    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready went low");

    // A result beat that is held back keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_skin) && $stable(o_frame_end)))
        else $error("stalled result beat changed or dropped");

endmodule

bind rgb_skin_classifier_dilate_top rscd_checker u_rscd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .pready      (pready),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_skin      (o_skin),
    .o_frame_end (o_frame_end)
);

`default_nettype wire
